// ===== rtl/core/software_timer_table_assert.svh =====
// Assertion macros shared by the timer table RTL
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define STT_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define STT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define STT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/stt_pkg.sv =====
// Types and codes of the software timer table
package stt_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EXPIRY = 2'd0,
		KIND_SET    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_COUNT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISSING  = 2'd1,
		ST_SHORT    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam int MAX_RESULTS = 16;
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [7:0]  task_id;
		logic [7:0]  signal_id;
		logic [30:0] period;
		logic [31:0] counter;
	} rec_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  event_task;
		logic [7:0]  event_signal;
		status_t     status;
	} resp_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  task_id;
		logic [7:0]  signal_id;
		logic [30:0] duty;
		logic        periodic;
	} cmd_t;

	typedef struct packed {
		resp_t       resp;
		logic [31:0] tick_count;
		logic        last;
	} out_t;

endpackage

// ===== rtl/core/stt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module stt_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/software_timer_table.sv =====
// Software timer table: top level with record walker and APB register
// Timers live in one RAM as records kept newest first, so entries 0 .. count-1
// are the live timers in age order; each tick, set and remove is a sweep over them,
// one record per cycle through the RAM's single read port while no tick waits for
// the output to take an expiry result. A set scans for its key; a new timer then
// shifts the table down. A remove scans the same way and closes the gap. A set
// whose duty is below the tick unit and a tick count read answer without a sweep.
// One operation is processed at a time; the last result may still wait in
// the output register while the next word is taken.
module software_timer_table #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // task_id[7:0], signal_id[15:8], duty[46:16], periodic[47]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // event_task[7:0], event_signal[15:8], status[17:16],
	                              // tick_count[49:18], zero[55:50]
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [2:0] {
		IDLE, SCAN, INS, INS0, RMV, TICK, RESP
	} state_t;

	state_t                st_q, st_d;
	logic [PW-1:0]         ptr_q, ptr_d, w_q, w_d, cnt_q, cnt_d;
	logic [PW-1:0]         ptr_inc, ptr_dec, w_inc;
	logic [stt_pkg::NRES_W-1:0] nres_q, nres_d;
	stt_pkg::resp_t        pend_q, pend_d;
	logic                  pend_v_q, pend_v_d;
	logic [31:0]           tot_q, tot_d;
	stt_pkg::cmd_t         cmd_q, cmd_d, cmd_in;
	stt_pkg::out_t         out_q, out_d;
	logic                  out_v_q, out_v_d;
	logic [15:0]           unit_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	stt_pkg::rec_t         wdata, rdata, newrec;
	logic                  out_free, match, expired, keep, counts, need_push;
	logic [32:0]           v;

	stt_ram #(
		.W ($bits(stt_pkg::rec_t)),
		.D (NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_d[AW-1:0]),
		.rdata (rdata)
	);

	assign cmd_in = '{operation: stt_pkg::op_t'(s_tuser), task_id: s_tdata[7:0],
		signal_id: s_tdata[15:8], duty: s_tdata[46:16], periodic: s_tdata[47]};

	assign s_tready = (st_q == IDLE);
	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.resp.kind;
	assign m_tdata  = {6'd0, out_q.tick_count, out_q.resp.status,
		out_q.resp.event_signal, out_q.resp.event_task};
	assign m_tlast  = out_q.last;
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {16'd0, unit_q};

	assign out_free = !out_v_q || m_tready;
	assign ptr_inc  = ptr_q + PW'(1);
	assign ptr_dec  = ptr_q - PW'(1);
	assign w_inc    = w_q + PW'(1);
	assign match    = (rdata.task_id == cmd_q.task_id) && (rdata.signal_id == cmd_q.signal_id);
	assign newrec   = '{task_id: cmd_q.task_id, signal_id: cmd_q.signal_id,
		period: cmd_q.periodic ? cmd_q.duty : 31'd0, counter: {1'b0, cmd_q.duty}};
	assign v        = {rdata.counter[31], rdata.counter} - {17'd0, unit_q};
	assign expired  = v[32] || (v == 33'd0);
	assign keep     = !expired || (rdata.period != 31'd0);
	assign counts   = expired && (nres_q < stt_pkg::NRES_W'(stt_pkg::MAX_RESULTS));
	assign need_push = counts && pend_v_q;

	always_comb begin
		st_d     = st_q;
		ptr_d    = ptr_q;
		w_d      = w_q;
		cnt_d    = cnt_q;
		nres_d   = nres_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		tot_d    = tot_q;
		cmd_d    = cmd_q;
		out_d    = out_q;
		out_v_d  = out_v_q && !m_tready;
		we       = 1'b0;
		waddr    = ptr_q[AW-1:0];
		wdata    = rdata;
		unique case (st_q)
			IDLE: begin
				ptr_d = '0;
				if (s_tvalid) begin
					cmd_d    = cmd_in;
					w_d      = '0;
					nres_d   = '0;
					pend_v_d = 1'b0;
					unique case (cmd_in.operation)
						stt_pkg::OP_TICK: begin
							tot_d = tot_q + {16'd0, unit_q};
							st_d  = (cnt_q == '0) ? RESP : TICK;
						end
						stt_pkg::OP_SET: begin
							if (cmd_in.duty < {15'd0, unit_q}) begin
								pend_d   = '{stt_pkg::KIND_SET, cmd_in.task_id,
									cmd_in.signal_id, stt_pkg::ST_SHORT};
								pend_v_d = 1'b1;
								st_d     = RESP;
							end else begin
								st_d = SCAN;
							end
						end
						stt_pkg::OP_REMOVE: st_d = SCAN;
						stt_pkg::OP_READ: begin
							pend_d   = '{stt_pkg::KIND_COUNT, 8'd0, 8'd0, stt_pkg::ST_OK};
							pend_v_d = 1'b1;
							st_d     = RESP;
						end
					endcase
				end
			end
			SCAN: begin
				pend_v_d = 1'b1;
				pend_d   = '{(cmd_q.operation == stt_pkg::OP_SET) ? stt_pkg::KIND_SET
					: stt_pkg::KIND_REMOVE, cmd_q.task_id, cmd_q.signal_id, stt_pkg::ST_OK};
				if (ptr_q == cnt_q) begin
					if (cmd_q.operation != stt_pkg::OP_SET) begin
						pend_d.status = stt_pkg::ST_MISSING;
						st_d = RESP;
					end else if (cnt_q == PW'(NUM_TIMERS)) begin
						pend_d.status = stt_pkg::ST_FULL;
						st_d = RESP;
					end else if (cnt_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = newrec;
						cnt_d = cnt_q + PW'(1);
						st_d  = RESP;
					end else begin
						ptr_d = cnt_q - PW'(1);
						st_d  = INS;
					end
				end else if (match) begin
					if (cmd_q.operation == stt_pkg::OP_SET) begin
						we    = 1'b1;
						wdata.counter = {1'b0, cmd_q.duty};
						st_d  = RESP;
					end else if (ptr_inc == cnt_q) begin
						cnt_d = cnt_q - PW'(1);
						st_d  = RESP;
					end else begin
						ptr_d = ptr_inc;
						st_d  = RMV;
					end
				end else begin
					ptr_d = ptr_inc;
				end
			end
			INS: begin
				we    = 1'b1;
				waddr = ptr_inc[AW-1:0];
				if (ptr_q == '0) begin
					st_d = INS0;
				end else begin
					ptr_d = ptr_dec;
				end
			end
			INS0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = newrec;
				cnt_d = cnt_q + PW'(1);
				st_d  = RESP;
			end
			RMV: begin
				we    = 1'b1;
				waddr = ptr_dec[AW-1:0];
				if (ptr_inc == cnt_q) begin
					cnt_d = cnt_q - PW'(1);
					st_d  = RESP;
				end else begin
					ptr_d = ptr_inc;
				end
			end
			TICK: begin
				if (!need_push || out_free) begin
					waddr = w_q[AW-1:0];
					wdata.counter = expired ? {1'b0, rdata.period} : v[31:0];
					if (keep) begin
						we  = 1'b1;
						w_d = w_inc;
					end
					if (counts) begin
						if (pend_v_q) begin
							out_d   = '{pend_q, tot_q, 1'b0};
							out_v_d = 1'b1;
						end
						pend_d   = '{stt_pkg::KIND_EXPIRY, rdata.task_id, rdata.signal_id,
							stt_pkg::ST_OK};
						pend_v_d = 1'b1;
						nres_d   = nres_q + stt_pkg::NRES_W'(1);
					end
					if (ptr_inc == cnt_q) begin
						cnt_d = keep ? w_inc : w_q;
						st_d  = RESP;
					end else begin
						ptr_d = ptr_inc;
					end
				end
			end
			RESP: begin
				if (!pend_v_q) begin
					st_d = IDLE;
				end else if (out_free) begin
					out_d    = '{pend_q, tot_q, 1'b1};
					out_v_d  = 1'b1;
					pend_v_d = 1'b0;
					st_d     = IDLE;
				end
			end
			default: st_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= IDLE;
			ptr_q    <= '0;
			w_q      <= '0;
			cnt_q    <= '0;
			nres_q   <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			tot_q    <= '0;
			cmd_q    <= '0;
			out_q    <= '0;
			out_v_q  <= 1'b0;
			unit_q   <= 16'd1;
		end else begin
			st_q     <= st_d;
			ptr_q    <= ptr_d;
			w_q      <= w_d;
			cnt_q    <= cnt_d;
			nres_q   <= nres_d;
			pend_q   <= pend_d;
			pend_v_q <= pend_v_d;
			tot_q    <= tot_d;
			cmd_q    <= cmd_d;
			out_q    <= out_d;
			out_v_q  <= out_v_d;
			if (psel && penable && pwrite && !paddr[2]) begin
				unit_q <= pwdata[15:0];
			end
		end
	end

`include "software_timer_table_assert.svh"

	`STT_CHECK(a_cnt_bound, cnt_q <= PW'(NUM_TIMERS), "fill count exceeds table size")
	`STT_IMPLY(a_tick_compact, st_q == TICK, w_q <= ptr_q, "compaction overtook walk")
	`STT_IMPLY(a_scan_range, st_q == SCAN, ptr_q <= cnt_q, "scan ran past fill count")
	`STT_NEXT(a_read_resp, s_tvalid && s_tready && s_tuser == stt_pkg::OP_READ, st_q == RESP, "no count reply")

endmodule

// ===== verif/software_timer_table_checker.sv =====
// Timer table checker: predicts each result word and compares it with the output stream
module software_timer_table_checker #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	localparam logic [2:0] ADDR_TICK_UNIT = 3'd0;

	typedef struct {
		stt_pkg::kind_t   kind;
		logic [7:0]       tid;
		logic [7:0]       sid;
		stt_pkg::status_t status;
		logic [31:0]      ticks;
		logic             last;
	} timer_result_t;

	timer_result_t result_q[$];

	logic [15:0] unit;
	logic        live[NUM_TIMERS];
	logic [7:0]  key_task[NUM_TIMERS];
	logic [7:0]  key_signal[NUM_TIMERS];
	logic [30:0] period[NUM_TIMERS];
	logic [31:0] counter[NUM_TIMERS];
	int          rank[NUM_TIMERS];
	logic [31:0] tick_total;

	initial begin
		fail_count = 0;
		checked = 0;
	end

	assign pending = result_q.size();

	task automatic post_result(input stt_pkg::kind_t k, input logic [7:0] t,
			input logic [7:0] s, input stt_pkg::status_t st);
		timer_result_t r;
		r.kind = k;
		r.tid = t;
		r.sid = s;
		r.status = st;
		r.ticks = tick_total;
		r.last = 1'b0;
		result_q.push_back(r);
	endtask

	task automatic release_timer(input int s);
		for (int i = 0; i < NUM_TIMERS; i++)
			if (live[i] && rank[i] > rank[s])
				rank[i]--;
		live[s] = 1'b0;
	endtask

	task automatic run_word(input stt_pkg::op_t op, input logic [7:0] t, input logic [7:0] g,
			input logic [30:0] duty, input logic per);
		int n;
		int cnt;
		int r;
		int s;
		longint v;
		stt_pkg::status_t st;
		n = 0;
		case (op)
			stt_pkg::OP_TICK: begin
				tick_total = tick_total + unit;
				cnt = 0;
				for (int i = 0; i < NUM_TIMERS; i++)
					if (live[i])
						cnt++;
				r = 0;
				while (r < cnt) begin
					s = -1;
					for (int i = 0; i < NUM_TIMERS; i++)
						if (live[i] && rank[i] == r)
							s = i;
					if (s < 0)
						break;
					v = longint'($signed(counter[s])) - longint'(unit);
					if (v <= 0) begin
						if (n < stt_pkg::MAX_RESULTS) begin
							post_result(stt_pkg::KIND_EXPIRY, key_task[s], key_signal[s],
								stt_pkg::ST_OK);
							n++;
						end
						if (period[s] != 0) begin
							counter[s] = {1'b0, period[s]};
							r++;
						end else begin
							release_timer(s);
							cnt--;
						end
					end else begin
						counter[s] = v[31:0];
						r++;
					end
				end
			end
			stt_pkg::OP_SET: begin
				st = stt_pkg::ST_OK;
				if (duty < unit) begin
					st = stt_pkg::ST_SHORT;
				end else begin
					s = -1;
					for (int i = NUM_TIMERS - 1; i >= 0; i--)
						if (live[i] && key_task[i] == t && key_signal[i] == g)
							s = i;
					if (s >= 0) begin
						counter[s] = {1'b0, duty};
					end else begin
						for (int i = NUM_TIMERS - 1; i >= 0; i--)
							if (!live[i])
								s = i;
						if (s < 0) begin
							st = stt_pkg::ST_FULL;
						end else begin
							for (int i = 0; i < NUM_TIMERS; i++)
								if (live[i])
									rank[i]++;
							live[s] = 1'b1;
							key_task[s] = t;
							key_signal[s] = g;
							counter[s] = {1'b0, duty};
							period[s] = per ? duty : '0;
							rank[s] = 0;
						end
					end
				end
				post_result(stt_pkg::KIND_SET, t, g, st);
				n = 1;
			end
			stt_pkg::OP_REMOVE: begin
				s = -1;
				for (int i = NUM_TIMERS - 1; i >= 0; i--)
					if (live[i] && key_task[i] == t && key_signal[i] == g)
						s = i;
				if (s >= 0)
					release_timer(s);
				post_result(stt_pkg::KIND_REMOVE, t, g,
					s >= 0 ? stt_pkg::ST_OK : stt_pkg::ST_MISSING);
				n = 1;
			end
			default: begin
				post_result(stt_pkg::KIND_COUNT, 8'd0, 8'd0, stt_pkg::ST_OK);
				n = 1;
			end
		endcase
		if (n > 0)
			result_q[result_q.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t e;
		if (!arst_n) begin
			unit = 16'd1;
			tick_total = '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				live[i] = 1'b0;
			result_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				checked++;
				if (result_q.size() == 0) begin
					$error("result word with nothing expected: kind %0d", m_tuser);
					fail_count++;
				end else begin
					e = result_q.pop_front();
					check_field("kind", e.kind, m_tuser);
					check_field("event_task", e.tid, m_tdata[7:0]);
					check_field("event_signal", e.sid, m_tdata[15:8]);
					check_field("status", e.status, m_tdata[17:16]);
					check_field("tick_count", e.ticks, m_tdata[49:18]);
					check_field("last", e.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				run_word(stt_pkg::op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
					s_tdata[46:16], s_tdata[47]);
			if (psel && penable && pwrite && pready && paddr == ADDR_TICK_UNIT)
				unit = pwdata[15:0];
		end
	end

endmodule

// ===== verif/software_timer_table_test.sv =====
// Timer table testbench: reset, register settings, directed and random words, verdict
module software_timer_table_test;

	localparam logic [2:0] ADDR_TICK_UNIT = 3'd0;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int checked;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int cycles = 0;
	int words_sent = 0;
	logic [15:0] cur_unit = 16'd1;
	logic [7:0] pool_task[24];
	logic [7:0] pool_signal[24];

	always #6 clk = ~clk;

	software_timer_table dut (.*);

	software_timer_table_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending, .checked
	);

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("software_timer_table test failed");
			$finish;
		end
	end

	task automatic send_word(input stt_pkg::op_t op, input logic [7:0] t, input logic [7:0] g,
			input logic [30:0] duty, input logic per);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {per, duty, g, t};
		forever begin
			#1;
			if (s_tready)
				break;
			@(negedge clk);
		end
		@(posedge clk);
		words_sent++;
	endtask

	task automatic write_unit(input logic [15:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_TICK_UNIT;
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_unit = v;
	endtask

	task automatic send_random(input int count);
		int k;
		int pick;
		logic [30:0] duty;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(23);
			pick = $urandom_range(99);
			if (pick < 10)
				duty = cur_unit == 0 ? 31'd0 : 31'($urandom_range(cur_unit - 1));
			else if (pick < 20)
				duty = 31'($urandom);
			else
				duty = 31'(cur_unit * $urandom_range(1, 5) + $urandom_range(cur_unit));
			pick = $urandom_range(99);
			if (pick < 35)
				send_word(stt_pkg::OP_TICK, 8'($urandom), 8'($urandom), 31'($urandom),
					1'($urandom));
			else if (pick < 70)
				send_word(stt_pkg::OP_SET, pool_task[k], pool_signal[k], duty, 1'($urandom));
			else if (pick < 90)
				send_word(stt_pkg::OP_REMOVE, pool_task[k], pool_signal[k], duty,
					1'($urandom));
			else
				send_word(stt_pkg::OP_READ, 8'($urandom), 8'($urandom), 31'($urandom),
					1'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < 24; i++) begin
			pool_task[i] = 8'($urandom);
			pool_signal[i] = 8'($urandom);
		end
		pool_task[0] = 8'd0;
		pool_signal[0] = 8'd0;
		pool_task[1] = 8'hff;
		pool_signal[1] = 8'hff;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unit 1, no idling
		send_word(stt_pkg::OP_READ, 8'd0, 8'd0, 31'd0, 1'b0);
		send_word(stt_pkg::OP_TICK, 8'd0, 8'd0, 31'd0, 1'b0);
		send_word(stt_pkg::OP_SET, 8'd5, 8'd5, 31'd0, 1'b0);
		send_word(stt_pkg::OP_SET, 8'd0, 8'd0, 31'd1, 1'b0);
		send_word(stt_pkg::OP_SET, 8'hff, 8'hff, 31'd2, 1'b1);
		send_word(stt_pkg::OP_SET, 8'd0, 8'd0, 31'd3, 1'b1);
		send_word(stt_pkg::OP_REMOVE, 8'd9, 8'd9, 31'd0, 1'b0);
		send_word(stt_pkg::OP_SET, 8'h5a, 8'ha5, 31'h7fffffff, 1'b1);
		repeat (3) send_word(stt_pkg::OP_TICK, 8'd0, 8'd0, 31'd0, 1'b0);
		send_word(stt_pkg::OP_REMOVE, 8'hff, 8'hff, 31'd0, 1'b0);
		send_word(stt_pkg::OP_REMOVE, 8'h5a, 8'ha5, 31'd0, 1'b0);
		for (int i = 0; i < 17; i++)
			send_word(stt_pkg::OP_SET, 8'(i + 16), 8'(255 - i), 31'd1, 1'(i));
		send_word(stt_pkg::OP_TICK, 8'd0, 8'd0, 31'd0, 1'b0);
		send_word(stt_pkg::OP_TICK, 8'd0, 8'd0, 31'd0, 1'b0);
		send_random(50);

		write_unit(16'hffff);
		send_idle = 84;
		send_random(60);

		write_unit(16'd7);
		send_idle = 0;
		recv_stall = 84;
		send_random(60);

		write_unit(16'd0);
		send_idle = 34;
		recv_stall = 34;
		send_random(50);

		// long output hold-off: fill the table, then tick while the output is blocked
		write_unit(16'd3);
		send_idle = 0;
		recv_stall = 0;
		for (int i = 0; i < 16; i++)
			send_word(stt_pkg::OP_SET, 8'(i), 8'(i + 100), 31'(3 + $urandom_range(2)),
				1'($urandom));
		hold_left = 800;
		send_random(40);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		send_random(40);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d words over five tick units (0, 1, 3, 7, 65535) and four idling mixes,",
			words_sent);
		$display("including a full table and a long output hold-off; %0d result words checked.",
			checked);
		if (fail_count == 0 && pending == 0)
			$display("software_timer_table test passed");
		else
			$display("software_timer_table test failed");
		$finish;
	end

endmodule
